// ----- rtl/erg_pkg.sv -----
// ----------------------------------------------------------------------------
// erg_pkg: shared types and helpers for the Euclidean rhythm generator
// Request/response structs, the status struct, and the mask helper functions
// used by the core and the top level.
// ----------------------------------------------------------------------------
package erg_pkg;

    localparam int MASK_W  = 64;
    localparam int LEN_W   = 7;
    localparam int FIELD_W = 8;

    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [FIELD_W-1:0] field_t;

    typedef struct packed {
        field_t hit_count;
        field_t step_count;
        field_t rotate_by;
    } erg_req_t;

    typedef struct packed {
        mask_t hit_mask;
        len_t  pattern_length;
        logic  too_long;
    } erg_rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } erg_stat_t;

    // Ones in the low n bits.
    function automatic mask_t len_mask(input len_t n);
        mask_t m;
        for (int i = 0; i < MASK_W; i++) begin
            m[i] = (len_t'(i) < n);
        end
        return m;
    endfunction

    function automatic mask_t bit_rev(input mask_t x);
        mask_t r;
        for (int i = 0; i < MASK_W; i++) begin
            r[i] = x[MASK_W-1-i];
        end
        return r;
    endfunction

endpackage

// ----- rtl/erg_shift.sv -----
// ----------------------------------------------------------------------------
// erg_shift: shared left shifter
// One 64-bit left shift; amounts of 64 and above give zero.
// ----------------------------------------------------------------------------
module erg_shift
    import erg_pkg::*;
(
    input  mask_t din,
    input  len_t  amt,
    output mask_t dout
);

    assign dout = din << amt;

endmodule

// ----- rtl/erg_core.sv -----
// ----------------------------------------------------------------------------
// erg_core: Bjorklund sequencer
// Holds the two group patterns and their counts, folds them down with the
// shared shifter, concatenates the groups and applies the rotation.
// ----------------------------------------------------------------------------
module erg_core
    import erg_pkg::*;
#(
    parameter int MAX_STEPS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  erg_req_t  req,
    input  logic      take,
    output erg_stat_t stat,
    output erg_rsp_t  rsp
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_CONCAT = 3'd2;
    localparam logic [2:0] ST_ROT_HI = 3'd3;
    localparam logic [2:0] ST_ROT_LO = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    mask_t      a_bits_reg, a_bits_next;
    mask_t      b_bits_reg, b_bits_next;
    len_t       a_len_reg, a_len_next;
    len_t       b_len_reg, b_len_next;
    len_t       a_cnt_reg, a_cnt_next;
    len_t       b_cnt_reg, b_cnt_next;
    len_t       pos_reg, pos_next;
    mask_t      acc_reg, acc_next;
    len_t       steps_reg, steps_next;
    len_t       rot_reg, rot_next;
    logic       rot_en_reg, rot_en_next;
    logic       too_long_reg, too_long_next;

    mask_t shift_in;
    len_t  shift_amt;
    mask_t shift_out;

    erg_shift u_shift (
        .din  (shift_in),
        .amt  (shift_amt),
        .dout (shift_out)
    );

    // operand select for the shared shifter
    always_comb
    begin
        case (state_reg)
            ST_REDUCE:
            begin
                shift_in  = b_bits_reg;
                shift_amt = a_len_reg;
            end
            ST_CONCAT:
            begin
                shift_in  = (a_cnt_reg != '0) ? a_bits_reg : b_bits_reg;
                shift_amt = pos_reg;
            end
            ST_ROT_HI:
            begin
                shift_in  = acc_reg;
                shift_amt = steps_reg - rot_reg;
            end
            ST_ROT_LO:
            begin
                shift_in  = bit_rev(acc_reg);
                shift_amt = rot_reg;
            end
            default:
            begin
                shift_in  = '0;
                shift_amt = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        a_bits_next   = a_bits_reg;
        b_bits_next   = b_bits_reg;
        a_len_next    = a_len_reg;
        b_len_next    = b_len_reg;
        a_cnt_next    = a_cnt_reg;
        b_cnt_next    = b_cnt_reg;
        pos_next      = pos_reg;
        acc_next      = acc_reg;
        steps_next    = steps_reg;
        rot_next      = rot_reg;
        rot_en_next   = rot_en_reg;
        too_long_next = too_long_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    acc_next      = '0;
                    too_long_next = 1'b0;
                    steps_next    = '0;
                    state_next    = ST_DONE;
                    if (req.step_count == '0)
                    begin
                        // empty pattern
                    end
                    else if (req.step_count > FIELD_W'(MAX_STEPS))
                    begin
                        too_long_next = 1'b1;
                    end
                    else
                    begin
                        steps_next = req.step_count[LEN_W-1:0];
                        if (req.hit_count >= req.step_count)
                        begin
                            acc_next = len_mask(req.step_count[LEN_W-1:0]);
                        end
                        else if (req.hit_count != '0)
                        begin
                            // hits in A groups, rests in B groups
                            a_bits_next = mask_t'(1);
                            b_bits_next = '0;
                            a_len_next  = len_t'(1);
                            b_len_next  = len_t'(1);
                            a_cnt_next  = req.hit_count[LEN_W-1:0];
                            b_cnt_next  = req.step_count[LEN_W-1:0]
                                          - req.hit_count[LEN_W-1:0];
                            pos_next    = '0;
                            rot_next    = req.rotate_by[LEN_W-1:0];
                            rot_en_next = (req.rotate_by != '0) &&
                                          (req.rotate_by < req.step_count);
                            state_next  = ST_REDUCE;
                        end
                    end
                end
            end
            ST_REDUCE:
            begin
                if (b_cnt_reg <= len_t'(1))
                begin
                    state_next = ST_CONCAT;
                end
                else
                begin
                    a_bits_next = a_bits_reg | shift_out;
                    a_len_next  = a_len_reg + b_len_reg;
                    if (a_cnt_reg <= b_cnt_reg)
                    begin
                        b_cnt_next = b_cnt_reg - a_cnt_reg;
                    end
                    else
                    begin
                        // leftover A groups become the remainder
                        b_bits_next = a_bits_reg;
                        b_len_next  = a_len_reg;
                        a_cnt_next  = b_cnt_reg;
                        b_cnt_next  = a_cnt_reg - b_cnt_reg;
                    end
                end
            end
            ST_CONCAT:
            begin
                if (a_cnt_reg != '0)
                begin
                    acc_next   = acc_reg | shift_out;
                    pos_next   = pos_reg + a_len_reg;
                    a_cnt_next = a_cnt_reg - len_t'(1);
                end
                else if (b_cnt_reg != '0)
                begin
                    acc_next   = acc_reg | shift_out;
                    pos_next   = pos_reg + b_len_reg;
                    b_cnt_next = b_cnt_reg - len_t'(1);
                end
                else
                begin
                    state_next = rot_en_reg ? ST_ROT_HI : ST_DONE;
                end
            end
            ST_ROT_HI:
            begin
                // low part of the pattern moves to the top of the window
                b_bits_next = shift_out & len_mask(steps_reg);
                state_next  = ST_ROT_LO;
            end
            ST_ROT_LO:
            begin
                // right shift by rot via reversed left shift
                acc_next   = b_bits_reg | bit_rev(shift_out);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_bits_reg   <= a_bits_next;
        b_bits_reg   <= b_bits_next;
        a_len_reg    <= a_len_next;
        b_len_reg    <= b_len_next;
        a_cnt_reg    <= a_cnt_next;
        b_cnt_reg    <= b_cnt_next;
        pos_reg      <= pos_next;
        acc_reg      <= acc_next;
        steps_reg    <= steps_next;
        rot_reg      <= rot_next;
        rot_en_reg   <= rot_en_next;
        too_long_reg <= too_long_next;
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);

    assign rsp.hit_mask       = acc_reg;
    assign rsp.pattern_length = steps_reg;
    assign rsp.too_long       = too_long_reg;

    // placed groups never run past the pattern length
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONCAT) |-> (pos_reg <= steps_reg))
        else $error("concat position beyond pattern length");

    // all groups placed: they fill the pattern exactly
    a_concat_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONCAT && a_cnt_reg == '0 && b_cnt_reg == '0)
        |-> (pos_reg == steps_reg))
        else $error("concatenated groups do not fill the pattern");

    // nothing set at or above the pattern length when done
    a_mask_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> ((acc_reg & ~len_mask(steps_reg)) == '0))
        else $error("mask bits beyond pattern length");

endmodule

// ----- rtl/euclidean_rhythm_generator.sv -----
// ----------------------------------------------------------------------------
// euclidean_rhythm_generator: Bjorklund Euclidean rhythm as a bit mask
// Top level: request handshake, sequencer core and response register.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req) carries hit_count,
//   step_count and rotate_by. Response channel (rsp_valid / rsp_stall / rsp)
//   carries hit_mask, pattern_length and too_long, one response per request.
//   A transfer happens on a rising edge with valid high and stall low.
// Sequence:
//   Special cases (zero steps, too many steps, zero hits, hits >= steps)
//   go from the request straight to the done state, then into the response
//   register. Full builds load the request, fold the groups (R subtractive
//   fold steps, at most steps-2), concatenate the a+b groups left after
//   folding (R+a+b never exceeds steps), rotate through ROT_HI and ROT_LO
//   when a rotation applies, then move the result into the response register.
//   All work runs through one shared 64-bit shifter.
// Throughput:
//   One request at a time; req_stall is high while the core is busy.
// Reset:
//   rst_n (async, active low) returns the core to idle and empties the
//   response register. No state survives between requests.
// Stall:
//   A response held by rsp_stall stays put; the core parks its next result
//   until the response register frees, and takes no request meanwhile.
// ----------------------------------------------------------------------------
module euclidean_rhythm_generator
    import erg_pkg::*;
#(
    parameter int MAX_STEPS = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  erg_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output erg_rsp_t rsp
);

    erg_stat_t stat;
    erg_rsp_t  core_rsp;
    logic      start;
    logic      load;
    logic      rsp_valid_reg, rsp_valid_next;
    erg_rsp_t  rsp_reg;

    // take a request only while the core is idle
    assign start     = req_valid && !stat.busy;
    assign req_stall = stat.busy;

    // move a finished result into the response register when it is free
    assign load = stat.done && (!rsp_valid_reg || !rsp_stall);

    erg_core #(
        .MAX_STEPS (MAX_STEPS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .take  (load),
        .stat  (stat),
        .rsp   (core_rsp)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= core_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // handing off a result frees the core on the next cycle
    a_core_freed: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (!stat.busy && rsp_valid_reg))
        else $error("core not idle after result handoff");

    // a stalled response holds its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> (rsp_valid_reg && $stable(rsp_reg)))
        else $error("stalled response changed");

    // an accepted request always occupies the core
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> stat.busy)
        else $error("core idle after accepted request");

endmodule
